// ===== src/accel_flick_detector_core_assert.svh =====
// Assertion macros used by the checker file of the flick detector.
`ifndef ACCEL_FLICK_DETECTOR_CORE_ASSERT_SVH
`define ACCEL_FLICK_DETECTOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AFD_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AFD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/afd_pkg.sv =====
package afd_pkg;

    // Item kinds carried on the input tuser.
    typedef enum logic [1:0]
    {
        OP_SAMPLE = 2'd0,
        OP_FAIL   = 2'd1,
        OP_TICK   = 2'd2,
        OP_TAKE   = 2'd3
    } afd_op_t;

    // Configuration register indexes.
    typedef enum logic [1:0]
    {
        REG_THRESHOLD = 2'd0,
        REG_HOLDOFF   = 2'd1,
        REG_MAX_ERR   = 2'd2,
        REG_UNUSED    = 2'd3
    } afd_reg_t;

    localparam int MG_W      = 12;   // signed milli-g, -2000..1999
    localparam int MG_SQ_W   = 22;   // square of one axis, up to 4000000
    localparam int MAG_W     = 24;   // sum of three squares
    localparam int HI_SQ_W   = 22;   // (1000 + threshold)^2
    localparam int LO_SQ_W   = 20;   // (1000 - threshold)^2
    localparam int RANGE_MG  = 2000;
    localparam int ONE_G_MG  = 1000;

    localparam logic [9:0]         RESET_THRESHOLD = 10'd600;
    localparam logic [15:0]        RESET_HOLDOFF   = 16'd250;
    localparam logic [7:0]         RESET_MAX_ERR   = 8'd20;
    localparam logic [HI_SQ_W-1:0] RESET_HI_SQ     = 22'd2560000;
    localparam logic [LO_SQ_W-1:0] RESET_LO_SQ     = 20'd160000;

    // Bit positions of the result word on the output tdata.
    localparam int OUT_TAKEN_BIT   = 0;
    localparam int OUT_SEEN_BIT    = 1;
    localparam int OUT_FIRED_BIT   = 2;
    localparam int OUT_RUNNING_BIT = 3;
    localparam int OUT_MAG_LSB     = 4;
    localparam int OUT_MAG_MSB     = OUT_MAG_LSB + MAG_W - 1;

    typedef struct packed
    {
        logic [HI_SQ_W-1:0] hi_sq;
        logic [LO_SQ_W-1:0] lo_sq;
        logic [15:0]        holdoff;
        logic [7:0]         max_errors;
    } afd_cfg_t;

    // Packed so that flap_taken sits in bit 0, padded to 32 bits.
    typedef struct packed
    {
        logic [3:0]       pad;
        logic [MAG_W-1:0] magnitude_sq;
        logic             sensor_running;
        logic             flap_fired;
        logic             flick_seen;
        logic             flap_taken;
    } afd_result_t;

endpackage

// ===== src/afd_lane.sv =====
module afd_lane #(
    parameter int RAW_BITS = 12
) (
    input  logic                         clk,
    input  logic                         en_conv,
    input  logic                         en_sq,
    input  logic [15:0]                  raw,
    output logic [afd_pkg::MG_SQ_W-1:0]  sq
);
    import afd_pkg::*;

    localparam int PROD_W = RAW_BITS + 11;

    logic [RAW_BITS-1:0]     biased;
    logic [PROD_W-1:0]       prod;
    logic [MG_W-1:0]         scaled;
    logic signed [MG_W:0]    mg_wide;
    logic signed [MG_W-1:0]  mg_reg;
    logic signed [2*MG_W-1:0] sq_full;
    logic [MG_SQ_W-1:0]      sq_reg;

    // Flipping the sign bit gives the offset-binary count, so the scale is unsigned.
    assign biased  = {~raw[15], raw[15-1 -: RAW_BITS-1]};
    assign prod    = PROD_W'(biased) * PROD_W'(RANGE_MG);
    assign scaled  = prod[RAW_BITS-1 +: MG_W];
    assign mg_wide = $signed({1'b0, scaled}) - $signed((MG_W+1)'(RANGE_MG));
    assign sq_full = mg_reg * mg_reg;

    always_ff @(posedge clk)
    begin
        if (en_conv)
        begin
            mg_reg <= mg_wide[MG_W-1:0];
        end
        if (en_sq)
        begin
            sq_reg <= sq_full[MG_SQ_W-1:0];
        end
    end

    assign sq = sq_reg;

endmodule

// ===== src/afd_merge.sv =====
module afd_merge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  afd_pkg::afd_op_t              op,
    input  logic [afd_pkg::MG_SQ_W-1:0]   sq_x,
    input  logic [afd_pkg::MG_SQ_W-1:0]   sq_y,
    input  logic [afd_pkg::MG_SQ_W-1:0]   sq_z,
    input  afd_pkg::afd_cfg_t             cfg,
    input  logic                          out_ready,
    output logic                          take,
    output logic                          out_valid,
    output afd_pkg::afd_result_t          result
);
    import afd_pkg::*;

    logic [MAG_W-1:0] mag_sum;
    logic             outside;
    logic [15:0]      holdoff_left_reg, holdoff_left_next;
    logic [7:0]       error_run_reg, error_run_next;
    logic             flap_waiting_reg, flap_waiting_next;
    logic             running_reg, running_next;
    logic             out_valid_reg, out_valid_next;
    afd_result_t      result_reg, result_next;

    assign take    = in_valid && (!out_valid_reg || out_ready);
    assign mag_sum = MAG_W'(sq_x) + MAG_W'(sq_y) + MAG_W'(sq_z);
    assign outside = (mag_sum > MAG_W'(cfg.hi_sq)) || (mag_sum < MAG_W'(cfg.lo_sq));

    always_comb
    begin
        holdoff_left_next = holdoff_left_reg;
        error_run_next    = error_run_reg;
        flap_waiting_next = flap_waiting_reg;
        running_next      = running_reg;
        result_next       = '0;
        out_valid_next    = out_valid_reg && !out_ready;

        if (take)
        begin
            out_valid_next = 1'b1;
            case (op)
                OP_SAMPLE:
                begin
                    if (running_reg)
                    begin
                        error_run_next           = '0;
                        result_next.magnitude_sq = mag_sum;
                        result_next.flick_seen   = outside;
                        if (outside && (holdoff_left_reg == '0))
                        begin
                            result_next.flap_fired = 1'b1;
                            flap_waiting_next      = 1'b1;
                            holdoff_left_next      = cfg.holdoff;
                        end
                    end
                end
                OP_FAIL:
                begin
                    if (running_reg)
                    begin
                        if (error_run_reg != 8'hFF)
                        begin
                            error_run_next = error_run_reg + 8'd1;
                        end
                        if (error_run_next >= cfg.max_errors)
                        begin
                            running_next = 1'b0;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (holdoff_left_reg != '0)
                    begin
                        holdoff_left_next = holdoff_left_reg - 16'd1;
                    end
                end
                OP_TAKE:
                begin
                    result_next.flap_taken = flap_waiting_reg;
                    flap_waiting_next      = 1'b0;
                end
                default:
                begin
                    result_next = '0;
                end
            endcase
            result_next.sensor_running = running_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_left_reg <= RESET_HOLDOFF;
            error_run_reg    <= '0;
            flap_waiting_reg <= 1'b0;
            running_reg      <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            holdoff_left_reg <= holdoff_left_next;
            error_run_reg    <= error_run_next;
            flap_waiting_reg <= flap_waiting_next;
            running_reg      <= running_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== src/accel_flick_detector_core.sv =====
// Flick detector for a three-axis accelerometer stream.
//
// Input items arrive on the s_axis channel. tuser carries the item kind
// (sample, read failure, millisecond tick, take-flap request) and tdata
// carries the three left-aligned axis words, x in the lowest 16 bits.
// Every input item produces exactly one result item on m_axis.
// Configuration registers (threshold, holdoff, failure limit) are written
// through the cfg channel, which is always ready; write them only while
// the block is idle, since the threshold squares take one cycle to settle.
//
// Each axis runs in its own lane: conversion to milli-g, then a squarer,
// each behind a register. A merge stage adds the three squares, compares
// against the band and updates the holdoff, failure and flap state.
// The conversion register loads when an item is accepted, then the squarer
// register and then the result register load as each stage moves on, so
// the result is valid once the result register has loaded the item.
// The block sustains one item per cycle while m_axis keeps up.
// Reset restores the register defaults, arms the holdoff at 250 ticks and
// starts detection running. When m_axis stalls, the result register holds
// and the pipeline fills; s_axis_tready drops only when all stages are full.
module accel_flick_detector_core #(
    parameter int RAW_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // accel_x_raw, accel_y_raw, accel_z_raw
    input  logic [1:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // flap_taken, flick_seen, flap_fired,
                                        // sensor_running, magnitude_sq[23:0], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import afd_pkg::*;

    logic               p1_valid_reg, p2_valid_reg;
    afd_op_t            p1_op_reg, p2_op_reg;
    logic               adv1, adv2, adv3;
    logic [MG_SQ_W-1:0] sq_x, sq_y, sq_z;

    logic [9:0]         threshold_reg;
    logic [15:0]        holdoff_reg;
    logic [7:0]         max_errors_reg;
    logic [HI_SQ_W-1:0] hi_sq_reg;
    logic [LO_SQ_W-1:0] lo_sq_reg;
    logic [10:0]        hi_val;
    logic signed [10:0] lo_val;
    logic [21:0]        hi_prod;
    logic signed [21:0] lo_prod;
    afd_cfg_t           cfg;
    afd_result_t        result;

    // Pipeline control: a stage moves when the stage after it is free or moving.
    assign adv2          = p1_valid_reg && (!p2_valid_reg || adv3);
    assign s_axis_tready = !p1_valid_reg || adv2;
    assign adv1          = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1 || adv2)
            begin
                p1_valid_reg <= adv1;
            end
            if (adv2 || adv3)
            begin
                p2_valid_reg <= adv2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            p1_op_reg <= afd_op_t'(s_axis_tuser);
        end
        if (adv2)
        begin
            p2_op_reg <= p1_op_reg;
        end
    end

    afd_lane #(.RAW_BITS(RAW_BITS)) u_lane_x
    (
        .clk     (clk),
        .en_conv (adv1),
        .en_sq   (adv2),
        .raw     (s_axis_tdata[15:0]),
        .sq      (sq_x)
    );

    afd_lane #(.RAW_BITS(RAW_BITS)) u_lane_y
    (
        .clk     (clk),
        .en_conv (adv1),
        .en_sq   (adv2),
        .raw     (s_axis_tdata[31:16]),
        .sq      (sq_y)
    );

    afd_lane #(.RAW_BITS(RAW_BITS)) u_lane_z
    (
        .clk     (clk),
        .en_conv (adv1),
        .en_sq   (adv2),
        .raw     (s_axis_tdata[47:32]),
        .sq      (sq_z)
    );

    // Configuration registers. Writes to an unlisted index are accepted and dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= RESET_THRESHOLD;
            holdoff_reg    <= RESET_HOLDOFF;
            max_errors_reg <= RESET_MAX_ERR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (afd_reg_t'(cfg_index))
                REG_THRESHOLD: threshold_reg  <= cfg_data[9:0];
                REG_HOLDOFF:   holdoff_reg    <= cfg_data;
                REG_MAX_ERR:   max_errors_reg <= cfg_data[7:0];
                default:       threshold_reg  <= threshold_reg;
            endcase
        end
    end

    // Band edges. The low edge goes negative for thresholds above one g and is
    // squared as a signed value.
    assign hi_val  = 11'(ONE_G_MG) + 11'(threshold_reg);
    assign lo_val  = $signed(11'(ONE_G_MG)) - $signed({1'b0, threshold_reg});
    assign hi_prod = 22'(hi_val) * 22'(hi_val);
    assign lo_prod = 22'(lo_val) * 22'(lo_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_sq_reg <= RESET_HI_SQ;
            lo_sq_reg <= RESET_LO_SQ;
        end
        else
        begin
            hi_sq_reg <= hi_prod[HI_SQ_W-1:0];
            lo_sq_reg <= lo_prod[LO_SQ_W-1:0];
        end
    end

    assign cfg.hi_sq      = hi_sq_reg;
    assign cfg.lo_sq      = lo_sq_reg;
    assign cfg.holdoff    = holdoff_reg;
    assign cfg.max_errors = max_errors_reg;

    afd_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p2_valid_reg),
        .op        (p2_op_reg),
        .sq_x      (sq_x),
        .sq_y      (sq_y),
        .sq_z      (sq_z),
        .cfg       (cfg),
        .out_ready (m_axis_tready),
        .take      (adv3),
        .out_valid (m_axis_tvalid),
        .result    (result)
    );

    assign m_axis_tdata = result;

endmodule

// ===== src/afd_checker.sv =====
`include "accel_flick_detector_core_assert.svh"

module afd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    import afd_pkg::*;

    logic stopped_reg;
    logic out_fire;

    assign out_fire = m_axis_tvalid && m_axis_tready;

    // Remembers that a delivered result has already reported detection stopped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg <= 1'b0;
        end
        else if (out_fire && !m_axis_tdata[OUT_RUNNING_BIT])
        begin
            stopped_reg <= 1'b1;
        end
    end

    `AFD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    `AFD_ASSERT_NOW(a_stop_sticky, clk, rst_n, m_axis_tvalid && stopped_reg, !m_axis_tdata[OUT_RUNNING_BIT], "detection restarted after stopping")

    `AFD_ASSERT_NOW(a_fire_needs_flick, clk, rst_n, m_axis_tvalid && m_axis_tdata[OUT_FIRED_BIT], m_axis_tdata[OUT_SEEN_BIT] && m_axis_tdata[OUT_RUNNING_BIT], "flap fired without a flick")

    `AFD_ASSERT_NOW(a_take_alone, clk, rst_n, m_axis_tvalid && m_axis_tdata[OUT_TAKEN_BIT], !m_axis_tdata[OUT_SEEN_BIT] && (m_axis_tdata[OUT_MAG_MSB:OUT_MAG_LSB] == '0), "take result carries sample data")

endmodule

bind accel_flick_detector_core afd_checker u_afd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
